// File: hw/rtl/vn_pkg.sv
// Shared types and constants for the vector normalizer.
`timescale 1ns / 1ps
package vn_pkg;
    localparam int unsigned CompW    = 16;
    localparam int unsigned MagW     = 16;
    localparam int unsigned SqW      = 31;
    localparam int unsigned LenSqW   = 32;
    localparam int unsigned LenW     = 16;
    localparam int unsigned QuotW    = 15;
    localparam int unsigned Lanes    = 3;
    localparam logic [LenSqW-1:0] EpsReset = 32'd655;
    localparam int unsigned SqrtStages = LenW;
    localparam int unsigned DivStages  = QuotW;
    // input register, square, sum, root, divide, merge
    localparam int unsigned Latency = 3 + SqrtStages + DivStages + 1;

    // Per-item control and operands carried alongside the root pipeline
    typedef struct packed {
        logic                             valid;
        logic                             short_f;
        logic [Lanes-1:0]                 neg;
        logic [Lanes-1:0][MagW-1:0]       mag;
    } vn_carry_t;

    // Control carried alongside the divider lanes
    typedef struct packed {
        logic             valid;
        logic             short_f;
        logic [Lanes-1:0] neg;
    } vn_ctrl_t;
endpackage

// File: hw/rtl/vector3_normalize.sv
// Top level of the 3D vector normalizer: squares, root, divider lanes, merge.
`timescale 1ns / 1ps
// Normalizes one Q7.8 vector per clock into Q1.14 components. busy is held
// low, so an item may be started on every cycle; each item gives exactly one
// result, marked by done, after the input register, square, sum and compare,
// 16 root stages, 15 divider stages in three parallel lanes, and merge. Results
// are in start order and cannot be held off. The user must write the threshold
// epsilon_squared through eps_we/eps_wdata only while no item is in flight;
// the block does not enforce this. It resets to 655. A vector with squared
// length below the threshold, or zero, gives too_short with zero components.
module vector3_normalize (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [vn_pkg::CompW-1:0]    comp_x,
    input  logic signed [vn_pkg::CompW-1:0]    comp_y,
    input  logic signed [vn_pkg::CompW-1:0]    comp_z,
    input  logic                               eps_we,
    input  logic [vn_pkg::LenSqW-1:0]          eps_wdata,
    output logic                               done,
    output logic signed [vn_pkg::CompW-1:0]    unit_x,
    output logic signed [vn_pkg::CompW-1:0]    unit_y,
    output logic signed [vn_pkg::CompW-1:0]    unit_z,
    output logic                               too_short
);
    import vn_pkg::*;

    logic [LenSqW-1:0] eps_reg;

    logic                         v0_reg, v1_reg, v2_reg;
    logic [Lanes-1:0]             neg0_reg, neg1_reg, neg2_reg;
    logic [Lanes-1:0][MagW-1:0]   mag0_reg, mag1_reg, mag2_reg;
    logic [Lanes-1:0][SqW-1:0]    sq1_reg;
    logic [LenSqW-1:0]            lensq_reg;
    logic                         short2_reg;
    logic [LenSqW-1:0]            lensq_next;

    vn_carry_t                    sq_carry, root_carry;
    logic [LenW-1:0]              root;
    vn_ctrl_t                     ctl0;
    vn_ctrl_t [DivStages-1:0]     ctl_reg;
    vn_ctrl_t [DivStages:0]       ctl_in;
    logic [Lanes-1:0][QuotW-1:0]  quot;

    logic                         done_reg, short_reg;
    logic [Lanes-1:0][CompW-1:0]  unit_reg;
    logic [Lanes-1:0][CompW-1:0]  comp;

    assign busy = 1'b0;
    assign comp = {comp_z, comp_y, comp_x};

    // Hold the threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            eps_reg <= EpsReset;
        else if (eps_we)
            eps_reg <= eps_wdata;
    end

    // Valid bits of the front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= start && !busy;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    // Take magnitudes, square them, then sum and compare
    always_comb
    begin
        lensq_next = LenSqW'(sq1_reg[0]) + LenSqW'(sq1_reg[1]) + LenSqW'(sq1_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < Lanes; l++)
        begin
            neg0_reg[l] <= comp[l][CompW-1];
            mag0_reg[l] <= comp[l][CompW-1] ? MagW'(-comp[l]) : comp[l];
            sq1_reg[l]  <= SqW'(SqW'(mag0_reg[l]) * SqW'(mag0_reg[l]));
        end
    end

    always_ff @(posedge clk)
    begin
        neg1_reg   <= neg0_reg;
        mag1_reg   <= mag0_reg;
        neg2_reg   <= neg1_reg;
        mag2_reg   <= mag1_reg;
        lensq_reg  <= lensq_next;
        short2_reg <= (lensq_next < eps_reg) || (lensq_next == '0);
    end

    always_comb
    begin
        sq_carry.valid   = v2_reg;
        sq_carry.short_f = short2_reg;
        sq_carry.neg     = neg2_reg;
        sq_carry.mag     = mag2_reg;
    end

    vn_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (lensq_reg),
        .carry_in  (sq_carry),
        .root      (root),
        .carry_out (root_carry)
    );

    // Divide each component by the length in its own lane
    for (genvar l = 0; l < Lanes; l++)
    begin : g_lane
        vn_div_lane u_div (
            .clk  (clk),
            .mag  (root_carry.mag[l]),
            .len  (root),
            .quot (quot[l])
        );
    end

    // Carry control next to the lanes
    always_comb
    begin
        ctl0.valid   = root_carry.valid;
        ctl0.short_f = root_carry.short_f;
        ctl0.neg     = root_carry.neg;
    end

    assign ctl_in = {ctl_reg, ctl0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl_in[DivStages-1:0];
    end

    // Merge lanes: apply signs, zero out refused vectors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= ctl_in[DivStages].valid;
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < Lanes; l++)
        begin
            if (ctl_in[DivStages].short_f)
                unit_reg[l] <= '0;
            else if (ctl_in[DivStages].neg[l])
                unit_reg[l] <= -{1'b0, quot[l]};
            else
                unit_reg[l] <= {1'b0, quot[l]};
        end
        short_reg <= ctl_in[DivStages].short_f;
    end

    assign done      = done_reg;
    assign unit_x    = unit_reg[0];
    assign unit_y    = unit_reg[1];
    assign unit_z    = unit_reg[2];
    assign too_short = short_reg;

    // Every start gives a result after the fixed latency, and only then
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(start, Latency) == done)
        else $error("result strobe out of step with start");

    // A refused vector gives zero components
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && too_short) |-> (unit_x == '0 && unit_y == '0 && unit_z == '0))
        else $error("too_short result with nonzero components");

    // Threshold write takes effect on the next cycle
    a_eps: assert property (@(posedge clk) disable iff (!rst_n)
        eps_we |=> (eps_reg == $past(eps_wdata)))
        else $error("threshold write lost");
endmodule

// File: hw/rtl/vn_sqrt.sv
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module vn_sqrt (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [vn_pkg::LenSqW-1:0]      value,
    input  vn_pkg::vn_carry_t              carry_in,
    output logic [vn_pkg::LenW-1:0]        root,
    output vn_pkg::vn_carry_t              carry_out
);
    import vn_pkg::*;

    logic [SqrtStages-1:0][LenSqW-1:0] val_reg;
    logic [SqrtStages-1:0][LenW+1:0]   rem_reg;
    logic [SqrtStages-1:0][LenW-1:0]   root_reg;
    vn_carry_t [SqrtStages-1:0]        car_reg;

    logic [SqrtStages-1:0][LenSqW-1:0] val_next;
    logic [SqrtStages-1:0][LenW+1:0]   rem_next;
    logic [SqrtStages-1:0][LenW-1:0]   root_next;

    logic [SqrtStages-1:0][LenW+3:0]   shifted;
    logic [SqrtStages-1:0][LenW+3:0]   trial;

    // Stage inputs: stage zero fed straight from the input, the rest from registers
    logic [SqrtStages:0][LenSqW-1:0]   val_in;
    logic [SqrtStages:0][LenW+1:0]     rem_in;
    logic [SqrtStages:0][LenW-1:0]     root_in;
    vn_carry_t [SqrtStages:0]          car_in;

    assign val_in  = {val_reg, value};
    assign rem_in  = {rem_reg, (LenW+2)'(0)};
    assign root_in = {root_reg, LenW'(0)};
    assign car_in  = {car_reg, carry_in};

    // Bring down two value bits, test and subtract the trial
    always_comb
    begin
        for (int s = 0; s < SqrtStages; s++)
        begin
            shifted[s]  = {rem_in[s], val_in[s][LenSqW-1 -: 2]};
            trial[s]    = {2'b00, root_in[s], 2'b01};
            val_next[s] = {val_in[s][LenSqW-3:0], 2'b00};
            if (shifted[s] >= trial[s])
            begin
                rem_next[s]  = (LenW+2)'(shifted[s] - trial[s]);
                root_next[s] = {root_in[s][LenW-2:0], 1'b1};
            end
            else
            begin
                rem_next[s]  = (LenW+2)'(shifted[s]);
                root_next[s] = {root_in[s][LenW-2:0], 1'b0};
            end
        end
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    // Advance carried control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            car_reg <= '0;
        else
            car_reg <= car_in[SqrtStages-1:0];
    end

    assign root      = root_in[SqrtStages];
    assign carry_out = car_in[SqrtStages];
endmodule

// File: hw/rtl/vn_div_lane.sv
// One divider lane: (mag * 2^14) / len, one quotient bit per stage.
`timescale 1ns / 1ps
module vn_div_lane (
    input  logic                      clk,
    input  logic [vn_pkg::MagW-1:0]   mag,
    input  logic [vn_pkg::LenW-1:0]   len,
    output logic [vn_pkg::QuotW-1:0]  quot
);
    import vn_pkg::*;

    logic [DivStages-1:0][LenW-1:0]  rem_reg;
    logic [DivStages-1:0][QuotW-1:0] low_reg;
    logic [DivStages-1:0][QuotW-1:0] quot_reg;
    logic [DivStages-1:0][LenW-1:0]  len_reg;

    logic [DivStages-1:0][LenW-1:0]  rem_next;
    logic [DivStages-1:0][QuotW-1:0] low_next;
    logic [DivStages-1:0][QuotW-1:0] quot_next;
    logic [DivStages-1:0][LenW:0]    shifted;
    logic [DivStages-1:0]            fits;

    logic [DivStages:0][LenW-1:0]    rem_in;
    logic [DivStages:0][QuotW-1:0]   low_in;
    logic [DivStages:0][QuotW-1:0]   quot_in;
    logic [DivStages:0][LenW-1:0]    len_in;

    // Dividend is mag << 14; the top part starts below len
    assign rem_in  = {rem_reg, {1'b0, mag[MagW-1:1]}};
    assign low_in  = {low_reg, {mag[0], (QuotW-1)'(0)}};
    assign quot_in = {quot_reg, QuotW'(0)};
    assign len_in  = {len_reg, len};

    // Shift in a dividend bit, subtract when it fits
    always_comb
    begin
        for (int s = 0; s < DivStages; s++)
        begin
            shifted[s]   = {rem_in[s], low_in[s][QuotW-1]};
            fits[s]      = shifted[s] >= {1'b0, len_in[s]};
            rem_next[s]  = fits[s] ? LenW'(shifted[s] - {1'b0, len_in[s]})
                                   : LenW'(shifted[s]);
            low_next[s]  = {low_in[s][QuotW-2:0], 1'b0};
            quot_next[s] = {quot_in[s][QuotW-2:0], fits[s]};
        end
    end

    // Advance all stages
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        quot_reg <= quot_next;
        len_reg  <= len_in[DivStages-1:0];
    end

    assign quot = quot_in[DivStages];
endmodule
